// File: sv/pts_pkg.sv
// ============================================================================
// pts_pkg: shared types and constants for the path to short name converter
// Holds the result record, the result kinds and the sizing of path state.
// ============================================================================
package pts_pkg;

    localparam int MAX_PARTS    = 16;
    localparam int BUFFER_BYTES = 256;

    localparam int CHAR_W   = 8;
    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;
    localparam int BASE_W   = BASE_LEN * CHAR_W;
    localparam int EXT_W    = EXT_LEN * CHAR_W;
    localparam int BFILL_W  = $clog2(BASE_LEN + 1);
    localparam int EFILL_W  = $clog2(EXT_LEN + 1);
    localparam int PARTS_W  = $clog2(MAX_PARTS + 1);
    localparam int BYTES_W  = $clog2(BUFFER_BYTES);
    localparam int INDEX_W  = 4;
    localparam int TOTAL_W  = 5;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_SEP   = 8'd47;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;

    localparam logic [BASE_W-1:0] BASE_SPACES = {BASE_LEN{CHAR_SPACE}};
    localparam logic [EXT_W-1:0]  EXT_SPACES  = {EXT_LEN{CHAR_SPACE}};

    // result queue: room for the two results one byte can cause, plus slack
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_END    = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BASE_W-1:0]   base_name;
        logic [EXT_W-1:0]    ext_name;
        logic [INDEX_W-1:0]  part_index;
        logic [TOTAL_W-1:0]  part_total;
        logic                last;
    } res_t;

    // up to two results written to the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic res_t make_name(logic [BASE_W-1:0] base, logic [EXT_W-1:0] ext,
                                       logic [PARTS_W-1:0] parts, logic last);
        res_t               r;
        logic [PARTS_W-1:0] idx;
        idx          = (parts != '0) ? parts - PARTS_W'(1) : '0;
        r.kind       = KIND_NAME;
        r.base_name  = base;
        r.ext_name   = ext;
        r.part_index = INDEX_W'(idx);
        r.part_total = '0;
        r.last       = last;
        return r;
    endfunction

    function automatic res_t make_end(logic [PARTS_W-1:0] parts);
        res_t r;
        r            = '0;
        r.kind       = KIND_END;
        r.part_total = TOTAL_W'(parts);
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic res_t make_reject();
        res_t r;
        r      = '0;
        r.kind = KIND_REJECT;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

// File: sv/path_to_short_names.sv
// A result is written into the result queue as its byte is taken and is offered on m_ once earlier results have left.
// Throughput: one byte per cycle; s_ready drops only while the four-entry result queue
// holds more than two results, so sustained rate follows the result drain of one per cycle.
// Reset: synchronous, active low; clears all path state and empties the result queue.
// A zero byte ends the path and returns the path state to its reset values.
// ============================================================================
// path_to_short_names: path to 8.3 short name converter
// Splits a byte stream path at slashes and packs each component as a base and extension.
// ============================================================================
module path_to_short_names (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_path_char,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_kind,
    output logic [63:0]  m_base_name,
    output logic [23:0]  m_ext_name,
    output logic [3:0]   m_part_index,
    output logic [4:0]   m_part_total,
    output logic         m_last
);

    logic                             in_part_reg,      in_part_next;
    logic                             seen_dot_reg,     seen_dot_next;
    logic [pts_pkg::BFILL_W-1:0]      base_fill_reg,    base_fill_next;
    logic [pts_pkg::EFILL_W-1:0]      ext_fill_reg,     ext_fill_next;
    logic [pts_pkg::BASE_W-1:0]       base_chars_reg,   base_chars_next;
    logic [pts_pkg::EXT_W-1:0]        ext_chars_reg,    ext_chars_next;
    logic [pts_pkg::PARTS_W-1:0]      parts_seen_reg,   parts_seen_next;
    logic [pts_pkg::BYTES_W-1:0]      bytes_stored_reg, bytes_stored_next;
    logic                             rejected_reg,     rejected_next;

    pts_pkg::push_t                   push;
    pts_pkg::res_t                    head;
    logic                             accept;
    logic [pts_pkg::CHAR_W-1:0]       up_char;

    assign accept  = s_valid && s_ready;
    assign up_char = (s_path_char inside {[8'd97:8'd122]}) ?
                     s_path_char - pts_pkg::CASE_DIFF : s_path_char;

    always_comb begin
        in_part_next      = in_part_reg;
        seen_dot_next     = seen_dot_reg;
        base_fill_next    = base_fill_reg;
        ext_fill_next     = ext_fill_reg;
        base_chars_next   = base_chars_reg;
        ext_chars_next    = ext_chars_reg;
        parts_seen_next   = parts_seen_reg;
        bytes_stored_next = bytes_stored_reg;
        rejected_next     = rejected_reg;
        push              = '0;

        if (accept) begin
            if (s_path_char == pts_pkg::CHAR_NUL) begin
                if (!rejected_reg) begin
                    if (in_part_reg) begin
                        push.cnt = 2'd2;
                        push.r0  = pts_pkg::make_name(base_chars_reg, ext_chars_reg,
                                                      parts_seen_reg, 1'b0);
                        push.r1  = pts_pkg::make_end(parts_seen_reg);
                    end else begin
                        push.cnt = 2'd1;
                        push.r0  = pts_pkg::make_end(parts_seen_reg);
                    end
                end
                in_part_next      = 1'b0;
                seen_dot_next     = 1'b0;
                base_fill_next    = '0;
                ext_fill_next     = '0;
                base_chars_next   = pts_pkg::BASE_SPACES;
                ext_chars_next    = pts_pkg::EXT_SPACES;
                parts_seen_next   = '0;
                bytes_stored_next = '0;
                rejected_next     = 1'b0;
            end else if (rejected_reg) begin
                // drop bytes until the path ends
            end else if (bytes_stored_reg >=
                         pts_pkg::BYTES_W'(pts_pkg::BUFFER_BYTES - 1)) begin
                rejected_next = 1'b1;
                push.cnt      = 2'd1;
                push.r0       = pts_pkg::make_reject();
            end else if (s_path_char == pts_pkg::CHAR_SEP) begin
                if (in_part_reg) begin
                    bytes_stored_next = bytes_stored_reg + pts_pkg::BYTES_W'(1);
                    in_part_next      = 1'b0;
                    push.cnt          = 2'd1;
                    push.r0           = pts_pkg::make_name(base_chars_reg, ext_chars_reg,
                                                           parts_seen_reg, 1'b1);
                    seen_dot_next     = 1'b0;
                    base_fill_next    = '0;
                    ext_fill_next     = '0;
                    base_chars_next   = pts_pkg::BASE_SPACES;
                    ext_chars_next    = pts_pkg::EXT_SPACES;
                end
            end else if (!in_part_reg &&
                         parts_seen_reg >= pts_pkg::PARTS_W'(pts_pkg::MAX_PARTS)) begin
                rejected_next = 1'b1;
                push.cnt      = 2'd1;
                push.r0       = pts_pkg::make_reject();
            end else begin
                // start a fresh component name on its first character
                if (!in_part_reg) begin
                    parts_seen_next = parts_seen_reg + pts_pkg::PARTS_W'(1);
                    in_part_next    = 1'b1;
                    seen_dot_next   = 1'b0;
                    base_fill_next  = '0;
                    ext_fill_next   = '0;
                    base_chars_next = pts_pkg::BASE_SPACES;
                    ext_chars_next  = pts_pkg::EXT_SPACES;
                end
                bytes_stored_next = bytes_stored_reg + pts_pkg::BYTES_W'(1);

                if (!seen_dot_next) begin
                    if (s_path_char == pts_pkg::CHAR_DOT) begin
                        seen_dot_next = 1'b1;
                    end else if (base_fill_next <
                                 pts_pkg::BFILL_W'(pts_pkg::BASE_LEN)) begin
                        for (int i = 0; i < pts_pkg::BASE_LEN; i++) begin
                            if (base_fill_next == pts_pkg::BFILL_W'(i)) begin
                                base_chars_next[(pts_pkg::BASE_LEN-1-i)*pts_pkg::CHAR_W
                                                +: pts_pkg::CHAR_W] = up_char;
                            end
                        end
                        base_fill_next = base_fill_next + pts_pkg::BFILL_W'(1);
                    end
                end else if (ext_fill_next < pts_pkg::EFILL_W'(pts_pkg::EXT_LEN)) begin
                    for (int i = 0; i < pts_pkg::EXT_LEN; i++) begin
                        if (ext_fill_next == pts_pkg::EFILL_W'(i)) begin
                            ext_chars_next[(pts_pkg::EXT_LEN-1-i)*pts_pkg::CHAR_W
                                           +: pts_pkg::CHAR_W] = up_char;
                        end
                    end
                    ext_fill_next = ext_fill_next + pts_pkg::EFILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_part_reg      <= 1'b0;
            seen_dot_reg     <= 1'b0;
            base_fill_reg    <= '0;
            ext_fill_reg     <= '0;
            base_chars_reg   <= pts_pkg::BASE_SPACES;
            ext_chars_reg    <= pts_pkg::EXT_SPACES;
            parts_seen_reg   <= '0;
            bytes_stored_reg <= '0;
            rejected_reg     <= 1'b0;
        end else begin
            in_part_reg      <= in_part_next;
            seen_dot_reg     <= seen_dot_next;
            base_fill_reg    <= base_fill_next;
            ext_fill_reg     <= ext_fill_next;
            base_chars_reg   <= base_chars_next;
            ext_chars_reg    <= ext_chars_next;
            parts_seen_reg   <= parts_seen_next;
            bytes_stored_reg <= bytes_stored_next;
            rejected_reg     <= rejected_next;
        end
    end

    pts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_kind       = head.kind;
    assign m_base_name  = head.base_name;
    assign m_ext_name   = head.ext_name;
    assign m_part_index = head.part_index;
    assign m_part_total = head.part_total;
    assign m_last       = head.last;

    a_base_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        base_fill_reg <= pts_pkg::BFILL_W'(pts_pkg::BASE_LEN))
        else $error("base fill past eight characters");

    a_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_stored_reg <= pts_pkg::BYTES_W'(pts_pkg::BUFFER_BYTES - 1))
        else $error("byte budget exceeded");

    a_parts: assert property (@(posedge aclk) disable iff (!aresetn)
        parts_seen_reg <= pts_pkg::PARTS_W'(pts_pkg::MAX_PARTS))
        else $error("part count past limit");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_path_char == pts_pkg::CHAR_NUL) |=>
        (parts_seen_reg == '0 && !rejected_reg && !in_part_reg))
        else $error("path state not cleared at end of path");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != pts_pkg::KIND_NAME) |-> m_last)
        else $error("end or reject beat without last");

endmodule

// File: sv/pts_queue.sv
// ============================================================================
// pts_queue: result queue
// Takes zero, one or two results a cycle and hands them out one beat at a time.
// ============================================================================
module pts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  pts_pkg::push_t    push,
    output logic              space_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output pts_pkg::res_t     head
);

    pts_pkg::res_t                  mem_reg [pts_pkg::QDEPTH];
    logic [pts_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pts_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pts_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];
    assign space_ok = (count_reg <= pts_pkg::QCNT_W'(pts_pkg::QDEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + pts_pkg::QPTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + pts_pkg::QPTR_W'(pop);
        count_next  = count_reg + pts_pkg::QCNT_W'(push.cnt) - pts_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + pts_pkg::QPTR_W'(1)] <= push.r1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pts_pkg::QCNT_W'(pts_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |-> space_ok)
        else $error("results written without room");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |=> (count_reg <= pts_pkg::QCNT_W'(2)))
        else $error("queue count jumped from empty");

endmodule
